### hw/rtl/monochrome_text_cell_renderer_top_macros.svh
// Assertion macros used by the checker file of the text cell renderer.
`ifndef MONOCHROME_TEXT_CELL_RENDERER_TOP_MACROS_SVH
`define MONOCHROME_TEXT_CELL_RENDERER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mtcr port check failed");

// Consequent must hold in the cycle after the antecedent.
`define MTCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mtcr port check failed");

`endif

### hw/rtl/mtcr_pkg.sv
// Types and constants of the monochrome text cell renderer.
`default_nettype none

package mtcr_pkg;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_FONT = 2'd1,
        REQ_TEXT = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        CFG_H_TOTAL    = 3'd0,
        CFG_H_DISP     = 3'd1,
        CFG_V_TOTAL    = 3'd2,
        CFG_V_ADJUST   = 3'd3,
        CFG_V_DISP     = 3'd4,
        CFG_MAX_SCAN   = 3'd5,
        CFG_START_ADDR = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  h_total;
        logic [7:0]  h_disp;
        logic [6:0]  v_total;
        logic [4:0]  v_adjust;
        logic [6:0]  v_disp;
        logic [4:0]  max_scan;
        logic [13:0] start_addr;
    } t_crtc_cfg;

    typedef struct packed {
        logic [7:0]  column;
        logic [12:0] line;
        logic        visible;
        logic        frame_end;
    } t_tick_info;

    // Division of a scan line by the 14-line character cell:
    // row = (line * CHAR_RECIP) >> RECIP_SHIFT is exact for all 13-bit lines.
    localparam logic [13:0] CHAR_RECIP  = 14'd9363;
    localparam int          RECIP_SHIFT = 17;
    localparam int          PROD_W      = 27;
    localparam int          ROW_W       = 10;

    localparam logic [11:0] UPPER_FONT  = 12'h800;

    localparam logic [7:0] ATTR_REV      = 8'h70;
    localparam logic [7:0] ATTR_REV_BLNK = 8'hF0;
    localparam logic [7:0] ATTR_REV_HI   = 8'h78;
    localparam logic [7:0] ATTR_REV_HIBL = 8'hF8;

    localparam logic [7:0] LEVEL_OFF    = 8'd0;
    localparam logic [7:0] LEVEL_NORMAL = 8'd127;
    localparam logic [7:0] LEVEL_BRIGHT = 8'd192;

endpackage

`default_nettype wire

### hw/rtl/mtcr_ifs.sv
// Channel interfaces of the text cell renderer: request, result and register write.
`default_nettype none

interface mtcr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [12:0] write_address;
    logic [7:0]  write_data;

    modport source (output valid, req_type, write_address, write_data, input ready);
    modport sink (input valid, req_type, write_address, write_data, output ready);
endinterface

interface mtcr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_column;
    logic [12:0] scan_line;
    logic        visible;
    logic        frame_end;
    logic [7:0]  pixel_0;
    logic [7:0]  pixel_1;
    logic [7:0]  pixel_2;
    logic [7:0]  pixel_3;
    logic [7:0]  pixel_4;
    logic [7:0]  pixel_5;
    logic [7:0]  pixel_6;
    logic [7:0]  pixel_7;

    modport source (output valid, cell_column, scan_line, visible, frame_end,
                    pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
                    pixel_7, input ready);
    modport sink (input valid, cell_column, scan_line, visible, frame_end,
                  pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
                  pixel_7, output ready);
endinterface

interface mtcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [13:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/mtcr_timing.sv
// Column and scan-line counters with display-area and frame-end decode.
`default_nettype none

module mtcr_timing (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire mtcr_pkg::t_crtc_cfg i_cfg,
    input  wire                 i_advance,
    output mtcr_pkg::t_tick_info o_info
);
    import mtcr_pkg::*;

    logic [7:0]  r_column;
    logic [12:0] r_line;

    logic [5:0]  w_lines_per_row;
    logic [12:0] w_vis_lines;
    logic [7:0]  w_rows;
    logic [12:0] w_total;
    logic [8:0]  w_next_col;
    logic [13:0] w_next_line;
    logic        w_wrap;
    logic        w_frame;

    assign w_lines_per_row = {1'b0, i_cfg.max_scan} + 6'd1;
    assign w_vis_lines     = 13'(i_cfg.v_disp) * 13'(w_lines_per_row);
    assign w_rows          = 8'(i_cfg.v_total) + 8'(i_cfg.v_adjust);
    assign w_total         = 13'(w_rows) * 13'(w_lines_per_row);

    // The carry bit lets a total of 255 still wrap the column.
    assign w_next_col  = {1'b0, r_column} + 9'd1;
    assign w_wrap      = w_next_col > {1'b0, i_cfg.h_total};
    assign w_next_line = {1'b0, r_line} + 14'd1;
    assign w_frame     = w_wrap && (w_next_line >= {1'b0, w_total});

    always_comb begin
        o_info.column    = r_column;
        o_info.line      = r_line;
        o_info.visible   = (r_column < i_cfg.h_disp) && (r_line < w_vis_lines);
        o_info.frame_end = w_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_line   <= '0;
        end else if (i_advance) begin
            if (w_wrap) begin
                r_column <= '0;
                r_line   <= w_frame ? '0 : w_next_line[12:0];
            end else begin
                r_column <= w_next_col[7:0];
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/monochrome_text_cell_renderer_top.sv
// Top level of the monochrome text cell renderer: register file, pipeline and stores.
`default_nettype none

// Monochrome text-mode renderer. Each tick request renders one character
// cell at the current column and scan line and returns its eight pixel
// levels; font and text write requests load the stores and return nothing.
// The block takes one request per clock cycle while the output is not held
// back, and a tick's result passes the row divide, cell address multiply,
// text buffer read and font read stages and then the output register. Text
// is held in even and odd banks so the character and attribute bytes come
// from a single read, and writes travel with the ticks so every tick sees
// the stores as they stood when it was accepted. FONT_BYTES and TEXT_BYTES
// must be powers of two. Registers are to be written by the user only while
// no request is in flight; the block itself does not enforce it. The register
// channel is always ready. The stores come up undefined and need no clearing.
module monochrome_text_cell_renderer_top #(
    parameter int FONT_BYTES = 8192,
    parameter int TEXT_BYTES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mtcr_in_if.sink     i_in,
    mtcr_out_if.source  o_out,
    mtcr_cfg_if.sink    i_cfg
);
    import mtcr_pkg::*;

    localparam int FW = $clog2(FONT_BYTES);
    localparam int TW = $clog2(TEXT_BYTES);
    localparam int BANK_DEPTH = TEXT_BYTES / 2;

    // Register file
    t_crtc_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_H_TOTAL:    r_cfg.h_total    <= i_cfg.data[7:0];
                CFG_H_DISP:     r_cfg.h_disp     <= i_cfg.data[7:0];
                CFG_V_TOTAL:    r_cfg.v_total    <= i_cfg.data[6:0];
                CFG_V_ADJUST:   r_cfg.v_adjust   <= i_cfg.data[4:0];
                CFG_V_DISP:     r_cfg.v_disp     <= i_cfg.data[6:0];
                CFG_MAX_SCAN:   r_cfg.max_scan   <= i_cfg.data[4:0];
                CFG_START_ADDR: r_cfg.start_addr <= i_cfg.data[13:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage moves when its successor has room.
    logic r_v1, r_v2, r_v3, r_v4, r_o_valid;
    logic [1:0] r_req4;
    logic w_adv_o, w_adv4, w_adv3, w_adv2, w_adv1;
    logic w_accept, w_tick_accept;

    assign w_adv_o = !r_o_valid || o_out.ready;
    assign w_adv4  = !r_v4 || w_adv_o;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;

    assign i_in.ready    = w_adv1;
    assign w_accept      = i_in.valid && w_adv1;
    assign w_tick_accept = w_accept && (i_in.req_type == REQ_TICK);

    t_tick_info w_info0;

    mtcr_timing u_timing (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (w_tick_accept),
        .o_info    (w_info0)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_in.valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
            if (w_adv_o) r_o_valid <= r_v4 && (r_req4 == REQ_TICK);
        end
    end

    // Stage 1: scan line times the reciprocal of the cell height.
    logic [1:0]        r_req1;
    t_tick_info        r_info1;
    logic [12:0]       r_waddr1;
    logic [7:0]        r_wdata1;
    logic [PROD_W-1:0] r_prod1;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_req1   <= i_in.req_type;
            r_info1  <= w_info0;
            r_waddr1 <= i_in.write_address;
            r_wdata1 <= i_in.write_data;
            r_prod1  <= PROD_W'(w_info0.line) * PROD_W'(CHAR_RECIP);
        end
    end

    // Stage 2: text row offset and font row.
    logic [ROW_W-1:0] w_row;
    logic [13:0]      w_row14;
    logic [12:0]      w_frow_full;

    assign w_row       = r_prod1[RECIP_SHIFT+ROW_W-1:RECIP_SHIFT];
    assign w_row14     = 14'({w_row, 4'b0}) - 14'({w_row, 1'b0});
    assign w_frow_full = r_info1.line - w_row14[12:0];

    logic [1:0]  r_req2;
    t_tick_info  r_info2;
    logic [12:0] r_waddr2;
    logic [7:0]  r_wdata2;
    logic [17:0] r_rowhd2;
    logic [3:0]  r_frow2;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_req2   <= r_req1;
            r_info2  <= r_info1;
            r_waddr2 <= r_waddr1;
            r_wdata2 <= r_wdata1;
            r_rowhd2 <= 18'(w_row) * 18'(r_cfg.h_disp);
            r_frow2  <= w_frow_full[3:0];
        end
    end

    // Stage 3: text buffer access. The character sits in the even bank and
    // the attribute in the odd bank of the same cell.
    logic [18:0] w_cell;
    logic [18:0] w_twaddr;
    logic        w_text_we;

    assign w_cell    = 19'(r_cfg.start_addr) + 19'(r_rowhd2) + 19'(r_info2.column);
    assign w_twaddr  = 19'(r_waddr2);
    assign w_text_we = w_adv3 && r_v2 && (r_req2 == REQ_TEXT);

    logic [7:0] r_text_even [BANK_DEPTH];
    logic [7:0] r_text_odd  [BANK_DEPTH];

    logic [1:0]  r_req3;
    t_tick_info  r_info3;
    logic [12:0] r_waddr3;
    logic [7:0]  r_wdata3;
    logic [3:0]  r_frow3;
    logic [7:0]  r_chr3;
    logic [7:0]  r_attr3;

    always_ff @(posedge i_clk) begin
        if (w_text_we && !w_twaddr[0]) r_text_even[w_twaddr[TW-1:1]] <= r_wdata2;
        if (w_text_we && w_twaddr[0]) r_text_odd[w_twaddr[TW-1:1]] <= r_wdata2;
        if (w_adv3) begin
            r_chr3  <= r_text_even[w_cell[TW-2:0]];
            r_attr3 <= r_text_odd[w_cell[TW-2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_req3   <= r_req2;
            r_info3  <= r_info2;
            r_waddr3 <= r_waddr2;
            r_wdata3 <= r_wdata2;
            r_frow3  <= r_frow2;
        end
    end

    // Stage 4: attribute decode and font store access.
    logic [7:0]  w_fg, w_bg;
    logic [11:0] w_chr14;
    logic [11:0] w_faddr;
    logic [18:0] w_faddr_ext;
    logic [18:0] w_fwaddr;
    logic        w_font_we;

    always_comb begin
        if (r_attr3 == ATTR_REV || r_attr3 == ATTR_REV_BLNK) begin
            w_fg = LEVEL_OFF;
            w_bg = LEVEL_BRIGHT;
        end else if (r_attr3 == ATTR_REV_HI || r_attr3 == ATTR_REV_HIBL) begin
            w_fg = LEVEL_NORMAL;
            w_bg = LEVEL_BRIGHT;
        end else begin
            w_fg = r_attr3[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
            w_bg = LEVEL_OFF;
        end
    end

    // Rows 8 to 13 of a glyph have bit 11 of their font address set (UPPER_FONT).
    assign w_chr14     = 12'({r_chr3, 4'b0}) - 12'({r_chr3, 1'b0});
    assign w_faddr     = (w_chr14 + 12'(r_frow3)) | (r_frow3[3] ? UPPER_FONT : 12'h000);
    assign w_faddr_ext = 19'(w_faddr);
    assign w_fwaddr    = 19'(r_waddr3);
    assign w_font_we   = w_adv4 && r_v3 && (r_req3 == REQ_FONT);

    logic [7:0] r_font [FONT_BYTES];

    t_tick_info r_info4;
    logic [7:0] r_fg4, r_bg4;
    logic [7:0] r_bits4;

    always_ff @(posedge i_clk) begin
        if (w_font_we) r_font[w_fwaddr[FW-1:0]] <= r_wdata3;
        if (w_adv4) r_bits4 <= r_font[w_faddr_ext[FW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_req4  <= r_req3;
            r_info4 <= r_info3;
            r_fg4   <= w_fg;
            r_bg4   <= w_bg;
        end
    end

    // Output register: pixel expansion, most significant font bit first.
    logic [7:0] w_pix [8];
    logic [7:0] r_pix [8];
    t_tick_info r_info_o;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (!r_info4.visible) begin
                w_pix[k] = LEVEL_OFF;
            end else begin
                w_pix[k] = r_bits4[7-k] ? r_fg4 : r_bg4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_o) begin
            r_info_o <= r_info4;
            for (int k = 0; k < 8; k++) begin
                r_pix[k] <= w_pix[k];
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.cell_column = r_info_o.column;
    assign o_out.scan_line   = r_info_o.line;
    assign o_out.visible     = r_info_o.visible;
    assign o_out.frame_end   = r_info_o.frame_end;
    assign o_out.pixel_0     = r_pix[0];
    assign o_out.pixel_1     = r_pix[1];
    assign o_out.pixel_2     = r_pix[2];
    assign o_out.pixel_3     = r_pix[3];
    assign o_out.pixel_4     = r_pix[4];
    assign o_out.pixel_5     = r_pix[5];
    assign o_out.pixel_6     = r_pix[6];
    assign o_out.pixel_7     = r_pix[7];

endmodule

`default_nettype wire

### hw/rtl/mtcr_checker.sv
// Port-level checker of the text cell renderer and its bind to the top level.
`default_nettype none

`include "monochrome_text_cell_renderer_top_macros.svh"

module mtcr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [7:0]  i_cell_column,
    input wire [12:0] i_scan_line,
    input wire        i_visible,
    input wire        i_frame_end,
    input wire [7:0]  i_pixel_0,
    input wire [7:0]  i_pixel_1,
    input wire [7:0]  i_pixel_2,
    input wire [7:0]  i_pixel_3,
    input wire [7:0]  i_pixel_4,
    input wire [7:0]  i_pixel_5,
    input wire [7:0]  i_pixel_6,
    input wire [7:0]  i_pixel_7
);
    logic        r_expect_origin;
    logic [63:0] w_pixels;
    logic        w_out_take;

    assign w_pixels   = {i_pixel_0, i_pixel_1, i_pixel_2, i_pixel_3,
                         i_pixel_4, i_pixel_5, i_pixel_6, i_pixel_7};
    assign w_out_take = i_out_valid && i_out_ready;

    // After a frame-end word, the next word must start the frame over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_origin <= 1'b0;
        end else if (w_out_take) begin
            r_expect_origin <= i_frame_end;
        end
    end

    `MTCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(w_pixels) && $stable(i_scan_line) && $stable(i_cell_column))

    `MTCR_ASSERT_NOW(a_blank_outside, i_clk, i_rst_n, i_out_valid && !i_visible, w_pixels == 64'd0)

    `MTCR_ASSERT_NOW(a_pixel_levels, i_clk, i_rst_n, i_out_valid && i_visible, (i_pixel_0 == 8'd0 || i_pixel_0 == 8'd127 || i_pixel_0 == 8'd192) && (i_pixel_7 == 8'd0 || i_pixel_7 == 8'd127 || i_pixel_7 == 8'd192))

    `MTCR_ASSERT_NOW(a_frame_restart, i_clk, i_rst_n, i_out_valid && r_expect_origin, i_cell_column == 8'd0 && i_scan_line == 13'd0)

endmodule

bind monochrome_text_cell_renderer_top mtcr_checker u_mtcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_cell_column (o_out.cell_column),
    .i_scan_line   (o_out.scan_line),
    .i_visible     (o_out.visible),
    .i_frame_end   (o_out.frame_end),
    .i_pixel_0     (o_out.pixel_0),
    .i_pixel_1     (o_out.pixel_1),
    .i_pixel_2     (o_out.pixel_2),
    .i_pixel_3     (o_out.pixel_3),
    .i_pixel_4     (o_out.pixel_4),
    .i_pixel_5     (o_out.pixel_5),
    .i_pixel_6     (o_out.pixel_6),
    .i_pixel_7     (o_out.pixel_7)
);

`default_nettype wire

### test/monochrome_text_cell_renderer_top_tb.sv
// Self-checking testbench of the text cell renderer: directed and random traffic scored against a predictor.
`timescale 1ns / 1ps

module monochrome_text_cell_renderer_top_tb;
    import mtcr_pkg::*;

    localparam int FONT_BYTES      = 8192;
    localparam int TEXT_BYTES      = 4096;
    localparam int CHAR_LINES      = 14;
    localparam int PIPE_LATENCY    = 5;
    localparam int SETTLE_CYCLES   = 3 * PIPE_LATENCY;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 2000000;

    // Request code 3 is not decoded by the block and must be dropped silently.
    localparam logic [1:0] REQ_NOISE = 2'd3;

    localparam logic [6:0][7:0] DIRECTED_ATTRS = {
        8'h00, 8'h0F, 8'h07, ATTR_REV_HIBL, ATTR_REV_HI, ATTR_REV_BLNK, ATTR_REV
    };

    typedef struct packed {
        t_tick_info      info;
        logic [7:0][7:0] pixel;
    } t_cell_result;

    typedef struct {
        logic [1:0]   req;
        logic [12:0]  addr;
        logic [7:0]   data;
        bit           has_cell;
        t_cell_result expected;
    } t_request;

    logic clk = 1'b0;
    logic rst_n;

    mtcr_in_if  in_ch ();
    mtcr_out_if out_ch ();
    mtcr_cfg_if cfg_ch ();

    monochrome_text_cell_renderer_top #(
        .FONT_BYTES(FONT_BYTES),
        .TEXT_BYTES(TEXT_BYTES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #2 clk = ~clk;

    // Shadow of the block's stores, counters and registers.
    bit [7:0]  font_shadow [FONT_BYTES];
    bit        font_known  [FONT_BYTES];
    bit [7:0]  text_shadow [TEXT_BYTES];
    bit        text_known  [TEXT_BYTES];
    int        column_now = 0;
    int        line_now   = 0;
    t_crtc_cfg crtc       = '0;

    t_request     request_queue [$];
    t_cell_result expected_cells [$];

    int   mismatch_count = 0;
    int   pushed_items   = 0;
    int   tx_idle_pct    = 0;
    int   rx_idle_pct    = 0;
    bit   in_taken       = 1'b0;
    bit   rx_hold        = 1'b0;
    event hold_kick;

    function automatic bit cell_visible();
        return column_now < int'(crtc.h_disp) &&
               line_now < int'(crtc.v_disp) * (int'(crtc.max_scan) + 1);
    endfunction

    // Byte address of the character of the current cell; the attribute follows it.
    function automatic int text_byte_addr();
        int cell_no;
        cell_no = int'(crtc.start_addr) + (line_now / CHAR_LINES) * int'(crtc.h_disp)
                  + column_now;
        return (cell_no * 2) % TEXT_BYTES;
    endfunction

    function automatic int font_byte_addr(input int chr);
        int frow;
        int addr;
        frow = line_now % CHAR_LINES;
        addr = chr * CHAR_LINES + frow;
        if (frow & 8) begin
            addr = addr | int'(UPPER_FONT);
        end
        return addr % FONT_BYTES;
    endfunction

    function automatic logic [7:0] random_attr();
        case ($urandom_range(7))
            0: return ATTR_REV;
            1: return ATTR_REV_BLNK;
            2: return ATTR_REV_HI;
            3: return ATTR_REV_HIBL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Applies one request to the shadow state and gives the cell it renders, if any.
    function automatic bit render_cell(input logic [1:0] req, input logic [12:0] addr,
                                       input logic [7:0] data, output t_cell_result rendered);
        int         taddr;
        int         total;
        int         k;
        logic [7:0] attr;
        logic [7:0] fg;
        logic [7:0] bg;
        logic [7:0] bits;
        rendered = '0;
        case (req)
            REQ_FONT: begin
                font_shadow[addr % FONT_BYTES] = data;
                font_known[addr % FONT_BYTES]  = 1'b1;
                return 1'b0;
            end
            REQ_TEXT: begin
                text_shadow[addr % TEXT_BYTES] = data;
                text_known[addr % TEXT_BYTES]  = 1'b1;
                return 1'b0;
            end
            REQ_TICK: begin
            end
            default: return 1'b0;
        endcase

        rendered.info.column  = column_now[7:0];
        rendered.info.line    = line_now[12:0];
        rendered.info.visible = cell_visible();
        if (rendered.info.visible) begin
            taddr = text_byte_addr();
            attr  = text_shadow[taddr + 1];
            if (attr == ATTR_REV || attr == ATTR_REV_BLNK) begin
                fg = LEVEL_OFF;
                bg = LEVEL_BRIGHT;
            end else if (attr == ATTR_REV_HI || attr == ATTR_REV_HIBL) begin
                fg = LEVEL_NORMAL;
                bg = LEVEL_BRIGHT;
            end else begin
                fg = attr[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
                bg = LEVEL_OFF;
            end
            bits = font_shadow[font_byte_addr(text_shadow[taddr])];
            for (k = 0; k < 8; k++) begin
                rendered.pixel[k] = bits[7 - k] ? fg : bg;
            end
        end

        // The column compare is done in full width so a total of 255 still wraps.
        if (column_now + 1 > int'(crtc.h_total)) begin
            column_now = 0;
            total = (int'(crtc.v_total) + int'(crtc.v_adjust)) * (int'(crtc.max_scan) + 1);
            line_now = line_now + 1;
            if (line_now >= total) begin
                line_now = 0;
                rendered.info.frame_end = 1'b1;
            end
        end else begin
            column_now = column_now + 1;
        end
        return 1'b1;
    endfunction

    function automatic void push_item(input logic [1:0] req, input logic [12:0] addr,
                                      input logic [7:0] data);
        t_request item;
        item.req      = req;
        item.addr     = addr;
        item.data     = data;
        item.has_cell = render_cell(req, addr, data, item.expected);
        request_queue.push_back(item);
        pushed_items++;
    endfunction

    // A visible tick must never read a byte that was never loaded, so the bytes it
    // will fetch are written first where they are still unknown.
    function automatic void push_tick();
        int taddr;
        int faddr;
        if (cell_visible()) begin
            taddr = text_byte_addr();
            if (!text_known[taddr]) begin
                push_item(REQ_TEXT, 13'(taddr + TEXT_BYTES * $urandom_range(1)),
                          8'($urandom_range(255)));
            end
            if (!text_known[taddr + 1]) begin
                push_item(REQ_TEXT, 13'(taddr + 1), random_attr());
            end
            faddr = font_byte_addr(text_shadow[taddr]);
            if (!font_known[faddr]) begin
                push_item(REQ_FONT, 13'(faddr), 8'($urandom_range(255)));
            end
        end
        push_item(REQ_TICK, 13'($urandom_range(8191)), 8'($urandom_range(255)));
    endfunction

    task automatic write_reg(input t_cfg_index reg_index, input logic [13:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= reg_index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic apply_crtc(input t_crtc_cfg setting);
        write_reg(CFG_H_TOTAL, 14'(setting.h_total));
        write_reg(CFG_H_DISP, 14'(setting.h_disp));
        write_reg(CFG_V_TOTAL, 14'(setting.v_total));
        write_reg(CFG_V_ADJUST, 14'(setting.v_adjust));
        write_reg(CFG_V_DISP, 14'(setting.v_disp));
        write_reg(CFG_MAX_SCAN, 14'(setting.max_scan));
        write_reg(CFG_START_ADDR, setting.start_addr);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        crtc = setting;
    endtask

    // Waits until every request is taken and every cell has come out, then lets
    // trailing writes leave the pipeline.
    task automatic wait_idle();
        int waited;
        while (request_queue.size() != 0) begin
            @(posedge clk);
        end
        waited = 0;
        while (expected_cells.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_cells.size() != 0) begin
            $display("%0d expected cells never came out", expected_cells.size());
            mismatch_count += expected_cells.size();
            expected_cells.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // Request driver and receiver back-pressure, both moved on the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!(in_ch.valid && !in_taken)) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_ch.valid         <= 1'b1;
                    in_ch.req_type      <= request_queue[0].req;
                    in_ch.write_address <= request_queue[0].addr;
                    in_ch.write_data    <= request_queue[0].data;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always begin
        @(hold_kick);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Monitor: books accepted requests and scores every cell that leaves the block.
    always @(posedge clk) begin : scoreboard
        t_cell_result want;
        t_cell_result got;
        int           k;
        if (!rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                if (request_queue[0].has_cell) begin
                    expected_cells.push_back(request_queue[0].expected);
                end
                void'(request_queue.pop_front());
            end
            if (out_ch.valid && out_ch.ready) begin
                got.info.column    = out_ch.cell_column;
                got.info.line      = out_ch.scan_line;
                got.info.visible   = out_ch.visible;
                got.info.frame_end = out_ch.frame_end;
                got.pixel = {out_ch.pixel_7, out_ch.pixel_6, out_ch.pixel_5, out_ch.pixel_4,
                             out_ch.pixel_3, out_ch.pixel_2, out_ch.pixel_1, out_ch.pixel_0};
                if (expected_cells.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected cell at column %0d line %0d",
                                 got.info.column, got.info.line);
                    end
                end else begin
                    want = expected_cells.pop_front();
                    check_field("cell_column", want.info.column, got.info.column);
                    check_field("scan_line", want.info.line, got.info.line);
                    check_field("visible", want.info.visible, got.info.visible);
                    check_field("frame_end", want.info.frame_end, got.info.frame_end);
                    for (k = 0; k < 8; k++) begin
                        check_field($sformatf("pixel_%0d", k), want.pixel[k], got.pixel[k]);
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_crtc_cfg setting;
        int        phase;
        int        phase_start;
        int        r;
        int        k;

        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.req_type      = REQ_TICK;
        in_ch.write_address = '0;
        in_ch.write_data    = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_H_TOTAL;
        cfg_ch.data         = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: one column, sixteen scan lines per frame, so the ticks walk
        // every font row of both halves and wrap the frame at the last line.
        tx_idle_pct = 16;
        rx_idle_pct = 88;
        setting = '0;
        setting.h_disp   = 8'd1;
        setting.v_total  = 7'd1;
        setting.v_disp   = 7'd1;
        setting.max_scan = 5'd15;
        apply_crtc(setting);
        push_item(REQ_TEXT, 13'd0, 8'h41);
        push_item(REQ_FONT, 13'(font_byte_addr(8'h41)), 8'hFF);
        push_item(REQ_FONT, 13'h1FFF, 8'h00);
        push_item(REQ_TEXT, 13'h1FFF, 8'hFF);
        push_item(REQ_NOISE, 13'h1FFF, 8'hFF);
        for (k = 0; k < 16; k++) begin
            if (k < 7) begin
                push_item(REQ_TEXT, 13'd1, DIRECTED_ATTRS[k]);
            end
            push_tick();
        end
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 4) begin
                tx_idle_pct = 16;
                rx_idle_pct = 88;
            end else if (phase < 7) begin
                tx_idle_pct = 88;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (phase == 0) begin
                setting.h_total    = 8'hFF;
                setting.h_disp     = 8'hFF;
                setting.v_total    = 7'h7F;
                setting.v_adjust   = 5'h1F;
                setting.v_disp     = 7'h7F;
                setting.max_scan   = 5'h1F;
                setting.start_addr = 14'h3FFF;
            end else if (phase == 4) begin
                setting = '0;
            end else begin
                // Small geometries so that lines and frames wrap within a phase.
                setting.h_total    = 8'($urandom_range(6));
                setting.h_disp     = 8'($urandom_range(8));
                setting.v_total    = 7'($urandom_range(3));
                setting.v_adjust   = 5'($urandom_range(2));
                setting.v_disp     = 7'($urandom_range(4));
                setting.max_scan   = 5'($urandom_range(15));
                setting.start_addr = 14'($urandom_range(16383));
            end
            apply_crtc(setting);

            // Every word sent counts, the store loads in front of a tick included.
            phase_start = pushed_items;
            while (pushed_items - phase_start < ITEMS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    push_tick();
                end else if (r < 78) begin
                    push_item(REQ_TEXT, 13'($urandom_range(8191)), random_attr());
                end else if (r < 96) begin
                    push_item(REQ_FONT, 13'($urandom_range(8191)), 8'($urandom_range(255)));
                end else begin
                    push_item(REQ_NOISE, 13'($urandom_range(8191)), 8'($urandom_range(255)));
                end
            end
            // Back-pressure the output while the sender keeps pushing words.
            if (phase == RANDOM_PHASES - 2) begin
                -> hold_kick;
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
